// ----- hdl/cda_pkg.sv -----
// Package with the beat types, field codes and month length table of the date adjuster.
`timescale 1ns / 1ps
package cda_pkg;

  // Item kinds.
  localparam logic [1:0] KindLoad = 2'd0;
  localparam logic [1:0] KindUp   = 2'd1;
  localparam logic [1:0] KindDown = 2'd2;

  // Field codes; FieldLoad reports a full load.
  localparam logic [2:0] FieldHour   = 3'd0;
  localparam logic [2:0] FieldMinute = 3'd1;
  localparam logic [2:0] FieldDay    = 3'd2;
  localparam logic [2:0] FieldMonth  = 3'd3;
  localparam logic [2:0] FieldYear   = 3'd4;
  localparam logic [2:0] FieldLoad   = 3'd5;

  // Field limits.
  localparam logic [4:0] HourMax   = 5'd23;
  localparam logic [5:0] MinuteMax = 6'd59;
  localparam logic [3:0] MonthMax  = 4'd12;
  localparam logic [6:0] YearMax   = 7'd99;
  localparam logic [4:0] LeapFeb   = 5'd29;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] field_select;
    logic [4:0] load_hour;
    logic [5:0] load_minute;
    logic [4:0] load_day;
    logic [3:0] load_month;
    logic [6:0] load_year;
  } cda_in_t;

  typedef struct packed {
    logic [4:0] hour_out;
    logic [5:0] minute_out;
    logic [4:0] day_out;
    logic [3:0] month_out;
    logic [6:0] year_out;
    logic [2:0] changed_field;
    logic       day_clamped;
  } cda_out_t;

  // Days in a month; a month code outside 1..12 counts as January.
  // February has 29 days when the two-digit year is a multiple of four.
  function automatic logic [4:0] month_len(logic [3:0] month, logic [6:0] year);
    logic [4:0] len;
    len = 5'd31;
    case (month) inside
      4'd2:                      len = (year[1:0] == 2'b00) ? LeapFeb : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ----- hdl/cda_if.sv -----
// Valid/ready channel interfaces for the input and result beats.
`timescale 1ns / 1ps
interface cda_in_if;
  logic             valid;
  logic             ready;
  cda_pkg::cda_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cda_out_if;
  logic              valid;
  logic              ready;
  cda_pkg::cda_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/clock_date_field_adjuster.sv -----
// Top level of the clock and calendar field adjuster.
// Path: an accepted input beat is held in the input register, and one combinational
// pass feeds its result into the result register.
// Throughput: one input beat per cycle while the result channel is not stalled; the
// held time and date update from the input register as each beat moves on.
// Reset: the time and date return to 00:00, day 1, month 1, year 0, and both
// stages are emptied.
`timescale 1ns / 1ps
module clock_date_field_adjuster (
  input logic       clk_i,
  input logic       rst_ni,
  cda_in_if.sink    in_i,
  cda_out_if.source out_o
);
  import cda_pkg::*;

  // Pipeline control and registers.
  logic       in_valid_q;
  cda_in_t    in_data_q;
  logic       out_valid_q;
  cda_out_t   out_data_q;
  logic       out_load;
  logic       in_load;

  // Held time and date.
  logic [4:0] hour_q,   hour_d;
  logic [5:0] minute_q, minute_d;
  logic [4:0] day_q,    day_d;
  logic [3:0] month_q,  month_d;
  logic [6:0] year_q,   year_d;

  logic       result_ok;
  logic       fit_day;
  logic [4:0] day_pre;
  logic [4:0] len_cur;
  logic [4:0] len_new;
  logic       clamp;

  // The result stage takes a beat when it is empty or being drained.
  assign out_load   = !out_valid_q || out_o.ready;
  assign in_load    = !in_valid_q || out_load;
  assign in_i.ready = in_load;

  // Unused kinds and unused fields give no result and leave the state alone.
  assign result_ok = (in_data_q.kind == KindLoad) ||
                     (((in_data_q.kind == KindUp) || (in_data_q.kind == KindDown)) &&
                      (in_data_q.field_select <= FieldYear));

  // A day step wraps at the length of the month that is held now.
  assign len_cur = month_len(month_q, year_q);

  // Next field values before the day is fitted to the month.
  always_comb begin
    hour_d   = hour_q;
    minute_d = minute_q;
    day_pre  = day_q;
    month_d  = month_q;
    year_d   = year_q;
    fit_day  = 1'b0;
    if (in_data_q.kind == KindLoad) begin
      hour_d   = (in_data_q.load_hour > HourMax) ? HourMax : in_data_q.load_hour;
      minute_d = (in_data_q.load_minute > MinuteMax) ? MinuteMax : in_data_q.load_minute;
      day_pre  = (in_data_q.load_day == 5'd0) ? 5'd1 : in_data_q.load_day;
      month_d  = (in_data_q.load_month == 4'd0) ? 4'd1 :
                 ((in_data_q.load_month > MonthMax) ? MonthMax : in_data_q.load_month);
      year_d   = (in_data_q.load_year > YearMax) ? YearMax : in_data_q.load_year;
      fit_day  = 1'b1;
    end else if (in_data_q.kind == KindUp) begin
      case (in_data_q.field_select)
        FieldHour:   hour_d   = (hour_q >= HourMax) ? 5'd0 : hour_q + 5'd1;
        FieldMinute: minute_d = (minute_q >= MinuteMax) ? 6'd0 : minute_q + 6'd1;
        FieldDay:    day_pre  = (day_q >= len_cur) ? 5'd1 : day_q + 5'd1;
        FieldMonth: begin
          month_d = (month_q >= MonthMax) ? 4'd1 : month_q + 4'd1;
          fit_day = 1'b1;
        end
        FieldYear: begin
          year_d  = (year_q >= YearMax) ? 7'd0 : year_q + 7'd1;
          fit_day = 1'b1;
        end
        default: ;
      endcase
    end else begin
      case (in_data_q.field_select)
        FieldHour:   hour_d   = (hour_q == 5'd0) ? HourMax : hour_q - 5'd1;
        FieldMinute: minute_d = (minute_q == 6'd0) ? MinuteMax : minute_q - 6'd1;
        FieldDay:    day_pre  = (day_q > 5'd1) ? day_q - 5'd1 : len_cur;
        FieldMonth: begin
          month_d = (month_q > 4'd1) ? month_q - 4'd1 : MonthMax;
          fit_day = 1'b1;
        end
        FieldYear: begin
          year_d  = (year_q == 7'd0) ? YearMax : year_q - 7'd1;
          fit_day = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // A load, month or year change pulls the day down to the new month length.
  assign len_new = month_len(month_d, year_d);
  assign clamp   = fit_day && (day_pre > len_new);
  assign day_d   = clamp ? len_new : day_pre;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_load) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load && in_i.valid) begin
      in_data_q <= in_i.data;
    end
  end

  // Held state updates when a valid item that gives a result leaves the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hour_q   <= 5'd0;
      minute_q <= 6'd0;
      day_q    <= 5'd1;
      month_q  <= 4'd1;
      year_q   <= 7'd0;
    end else if (in_valid_q && out_load && result_ok) begin
      hour_q   <= hour_d;
      minute_q <= minute_d;
      day_q    <= day_d;
      month_q  <= month_d;
      year_q   <= year_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= in_valid_q && result_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && in_valid_q && result_ok) begin
      out_data_q.hour_out      <= hour_d;
      out_data_q.minute_out    <= minute_d;
      out_data_q.day_out       <= day_d;
      out_data_q.month_out     <= month_d;
      out_data_q.year_out      <= year_d;
      out_data_q.changed_field <= (in_data_q.kind == KindLoad) ? FieldLoad
                                                               : in_data_q.field_select;
      out_data_q.day_clamped   <= clamp;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // The held date always stays a real calendar date.
  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (month_q >= 4'd1) && (month_q <= MonthMax))
    else $error("month left 1..12");

  a_day_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (day_q >= 5'd1) && (day_q <= month_len(month_q, year_q)))
    else $error("day outside month length");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hour_q <= HourMax) && (minute_q <= MinuteMax) && (year_q <= YearMax))
    else $error("hour, minute or year out of range");

  // Only a load, month or year change can pull the day down.
  a_clamp_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q.day_clamped) |->
      ((out_data_q.changed_field == FieldLoad) || (out_data_q.changed_field == FieldMonth) ||
       (out_data_q.changed_field == FieldYear)))
    else $error("day clamp on a field that cannot clamp");

  // A result beat mirrors the held state it produced.
  a_out_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ((out_data_q.day_out == day_q) && (out_data_q.month_out == month_q)
                           && (out_data_q.hour_out == hour_q)))
    else $error("result beat differs from held state");

endmodule
